[src/frc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_pkg: shared types and constants for the frame CRC-16 checker
// Word layouts of both channels, status codes and frame constants.
// ----------------------------------------------------------------------------
package frc_pkg;

    // Frame constants
    localparam int          MAX_FRAME_BYTES_DEF = 252;
    localparam logic [15:0] CRC_INIT            = 16'hFFFF;
    localparam logic [8:0]  HEADER_EXTRA        = 9'd12;
    localparam logic [8:0]  POS_MAX             = 9'd511;

    // Byte positions inside the header
    localparam logic [8:0]  POS_CRC_LO = 9'd0;
    localparam logic [8:0]  POS_CRC_HI = 9'd1;
    localparam logic [8:0]  POS_SIZE   = 9'd2;

    // Status codes, in order of the protocol's numbering
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_TOO_BIG = 2'd1,
        STATUS_SHORT   = 2'd2,
        STATUS_CRC_BAD = 2'd3
    } frame_status_t;

    // Input word: one received byte
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } rx_word_t;

    // Output word: one status per frame
    typedef struct packed {
        frame_status_t frame_status;
        logic [15:0]   computed_crc;
        logic [8:0]    declared_length;
    } status_word_t;

endpackage

[src/frc_crc_byte.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_crc_byte: byte-wise CRC-16 update
// Polynomial 0x1021, no reflection; folds one byte into the running CRC.
// ----------------------------------------------------------------------------
module frc_crc_byte
    import frc_pkg::*;
(
    input  logic [15:0] crc,
    input  logic [7:0]  data,
    output logic [15:0] crc_next
);

    logic [7:0] x_raw;
    logic [7:0] x_mix;

    // Table-free form of the 0x1021 byte step
    assign x_raw    = crc[15:8] ^ data;
    assign x_mix    = x_raw ^ {4'd0, x_raw[7:4]};
    assign crc_next = {crc[7:0], 8'd0}
                    ^ {x_mix[3:0], 12'd0}
                    ^ {3'd0, x_mix, 5'd0}
                    ^ {8'd0, x_mix};

endmodule

[src/frame_crc16_checker_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_crc16_checker_top: receive-frame CRC-16 checker
// Takes frame bytes in order, tracks header fields and the CRC, and returns
// one status word on the byte flagged as end of frame.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+---------------------------
//   in      | input     | in_valid / in_ready  | rx_word_t  (byte, eof)
//   out     | output    | out_valid / out_ready| status_word_t (status,
//           |           |                      |   crc, declared length)
//
// One byte per cycle while in_ready is high; the status word appears in the cycle after the last byte.
// The frame state and the output register are both loaded straight from the
// next-state logic; the CRC byte update is the longest path.
// in_ready drops only while a status word waits and out_ready is low.
// Reset returns the frame state to its initial values and empties the output register.
// ----------------------------------------------------------------------------
module frame_crc16_checker_top
    import frc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  rx_word_t     in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output status_word_t out_data
);

    localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME_BYTES);

    // Frame state
    logic [15:0]  crc_reg,    crc_next;
    logic [8:0]   pos_reg,    pos_next;
    logic [15:0]  stored_reg, stored_next;
    logic [8:0]   len_reg,    len_next;

    // Output register
    logic         out_valid_reg, out_valid_next;
    status_word_t out_data_reg,  out_data_next;

    logic         accept;
    logic [8:0]   len_eff;
    logic [15:0]  crc_upd;
    logic [15:0]  crc_new;
    logic [15:0]  stored_new;
    logic [9:0]   pos_plus1;
    frame_status_t status;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    frc_crc_byte u_crc
    (
        .crc      (crc_reg),
        .data     (in_data.rx_byte),
        .crc_next (crc_upd)
    );

    // Header capture and CRC gating for the current byte
    always_comb
    begin
        stored_new = stored_reg;
        len_eff    = len_reg;
        crc_new    = crc_reg;
        if (pos_reg == POS_CRC_LO)
        begin
            stored_new = {stored_reg[15:8], in_data.rx_byte};
        end
        else if (pos_reg == POS_CRC_HI)
        begin
            stored_new = {in_data.rx_byte, stored_reg[7:0]};
        end
        else
        begin
            if (pos_reg == POS_SIZE)
            begin
                len_eff = {1'b0, in_data.rx_byte} + HEADER_EXTRA;
            end
            if (pos_reg < len_eff)
            begin
                crc_new = crc_upd;
            end
        end
        pos_plus1 = {1'b0, pos_reg} + 10'd1;
    end

    // Status for a byte flagged as end of frame
    always_comb
    begin
        priority if (pos_reg < POS_SIZE)
            status = STATUS_SHORT;
        else if (len_eff > MAX_LEN)
            status = STATUS_TOO_BIG;
        else if (pos_plus1 < {1'b0, len_eff})
            status = STATUS_SHORT;
        else if (crc_new != stored_new)
            status = STATUS_CRC_BAD;
        else
            status = STATUS_OK;
    end

    // Next frame state and output word
    always_comb
    begin
        crc_next       = crc_reg;
        pos_next       = pos_reg;
        stored_next    = stored_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            if (in_data.end_of_frame)
            begin
                crc_next       = CRC_INIT;
                pos_next       = '0;
                stored_next    = '0;
                len_next       = '0;
                out_valid_next = 1'b1;
                out_data_next.frame_status    = status;
                out_data_next.computed_crc    = crc_new;
                out_data_next.declared_length = len_eff;
            end
            else
            begin
                crc_next    = crc_new;
                stored_next = stored_new;
                len_next    = len_eff;
                pos_next    = (pos_reg == POS_MAX) ? pos_reg : pos_plus1[8:0];
            end
        end
    end

    // Control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_INIT;
            pos_reg       <= '0;
            stored_reg    <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            pos_reg       <= pos_next;
            stored_reg    <= stored_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

[src/frc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_checker: port-level checks for the frame CRC-16 checker
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module frc_checker
    import frc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_ready,
    input  rx_word_t     in_data,
    input  logic         out_valid,
    input  logic         out_ready,
    input  status_word_t out_data
);

    // A waiting status word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("status word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("status word changed while stalled");

    // Last byte of a frame gives a status word next cycle
    a_eof_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.end_of_frame |=> out_valid)
        else $error("no status after end of frame");

    // Other bytes give none
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_data.end_of_frame && (!out_valid || out_ready)
        |=> !out_valid)
        else $error("status word without end of frame");

    // Declared length is either zero or at least HEADER_EXTRA
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.declared_length == 9'd0)
                   || (out_data.declared_length >= HEADER_EXTRA))
        else $error("declared length out of range");

endmodule

bind frame_crc16_checker_top frc_checker u_frc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
